FILE: rtl/core/rmm_pkg.sv
// ----------------------------------------------------------------------------
// rmm_pkg
// shared constants and types for the running median block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmm_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int MED_BITS   = VALUE_BITS + 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int IN_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((MED_BITS + 7) / 8) * 8;
  localparam int STATUS_W   = 2;

  localparam logic [STATUS_W-1:0] ST_VALID    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_HELD = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // one command to every cell of the chain, at most one bit set
  typedef struct packed {
    logic cmp;
    logic ins;
    logic rem;
  } rmm_cmd_t;

endpackage

FILE: rtl/core/running_median_multiset.sv
// ----------------------------------------------------------------------------
// running_median_multiset
// sorted multiset with insert and remove, reports twice the running median
// ----------------------------------------------------------------------------
// flow: an accepted item runs through compare, shift, select and sum before
// out_tvalid rises; the output register can wait on out_tready
// one item at a time: a new item is taken only in idle, after the last one has
// run the compare/shift/readout/output sequence and handed its result over
// reset: rst_n low clears the held count, all cell occupancy and the output
// valid flag; stored values stay undefined until written
`timescale 1ns / 1ps

module running_median_multiset
  import rmm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input item channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] value
  input  logic [0:0]             in_tuser,   // [0] action
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [32:0] median_twice
  output logic [STATUS_W-1:0]    out_tuser   // [1:0] status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_SEL,
    S_OUT
  } state_t;

  state_t                       state_r;
  logic                         act_r;
  logic signed [VALUE_BITS-1:0] val_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [CNT_W-1:0]             cnt_nxt;
  logic [STATUS_W-1:0]          status_r;
  logic [VALUE_BITS-1:0]        lo_r;
  logic [VALUE_BITS-1:0]        hi_r;

  logic                         out_valid_r;
  logic [STATUS_W-1:0]          out_status_r;
  logic [MED_BITS-1:0]          out_med_r;

  rmm_cmd_t                     cmd;
  logic                         found;
  logic [VALUE_BITS-1:0]        lo_val;
  logic [VALUE_BITS-1:0]        hi_val;
  logic [IDX_W-1:0]             half;
  logic [IDX_W-1:0]             lo_idx;
  logic [IDX_W-1:0]             hi_idx;
  logic                         full;
  logic [MED_BITS-1:0]          med_sum;

  assign in_tready = (state_r == S_IDLE);
  assign full      = (cnt_r == CNT_W'(CAPACITY));

  // chain command: compare once, then shift only when the item really changes the set
  always_comb begin
    cmd     = '0;
    cnt_nxt = cnt_r;
    case (state_r)
      S_CMP: cmd.cmp = 1'b1;
      S_UPD: begin
        if (act_r == ACT_INSERT) begin
          if (!full) begin
            cmd.ins = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end else if (found) begin
          cmd.rem = 1'b1;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // middle positions from the updated count
  assign half   = IDX_W'(cnt_r >> 1);
  assign hi_idx = half;
  assign lo_idx = cnt_r[0] ? half : half - IDX_W'(1);

  assign med_sum = $signed({lo_r[VALUE_BITS-1], lo_r}) + $signed({hi_r[VALUE_BITS-1], hi_r});

  rmm_chain u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .v      (val_r),
    .lo_idx (lo_idx),
    .hi_idx (hi_idx),
    .found  (found),
    .lo_val (lo_val),
    .hi_val (hi_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_OUT the handover below decides the output register
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            act_r   <= in_tuser[0];
            val_r   <= $signed(in_tdata[VALUE_BITS-1:0]);
            state_r <= S_CMP;
          end
        end
        S_CMP: state_r <= S_UPD;
        S_UPD: begin
          cnt_r <= cnt_nxt;
          if (act_r == ACT_INSERT) begin
            status_r <= full ? ST_FULL : ST_VALID;
          end else if (!found) begin
            status_r <= ST_NOT_HELD;
          end else if (cnt_nxt == '0) begin
            status_r <= ST_EMPTY;
          end else begin
            status_r <= ST_VALID;
          end
          state_r <= S_SEL;
        end
        S_SEL: begin
          lo_r    <= lo_val;
          hi_r    <= hi_val;
          state_r <= S_OUT;
        end
        S_OUT: begin
          // output register frees up: hand over the result
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_med_r    <= (status_r == ST_VALID) ? med_sum : '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_TDATA_W'(out_med_r);

endmodule

FILE: rtl/core/rmm_cell.sv
// ----------------------------------------------------------------------------
// rmm_cell
// one slot of the sorted chain: holds a value, compares, shifts left or right
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmm_cell
  import rmm_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  rmm_cmd_t                     cmd,
  input  logic signed [VALUE_BITS-1:0] v,
  input  logic [IDX_W-1:0]             idx,
  input  logic [IDX_W-1:0]             lo_idx,
  input  logic [IDX_W-1:0]             hi_idx,
  input  logic [VALUE_BITS-1:0]        left_val,
  input  logic                         left_occ,
  input  logic                         left_le,
  input  logic [VALUE_BITS-1:0]        right_val,
  input  logic                         right_occ,
  output logic [VALUE_BITS-1:0]        val,
  output logic                         occ,
  output logic                         le,
  output logic                         ge,
  output logic [VALUE_BITS-1:0]        lo_val,
  output logic [VALUE_BITS-1:0]        hi_val
);

  logic signed [VALUE_BITS-1:0] val_r;
  logic                         occ_r;
  logic                         le_r;   // held value <= v
  logic                         ge_r;   // held value >= v

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      le_r  <= 1'b0;
      ge_r  <= 1'b0;
    end else if (cmd.cmp) begin
      le_r <= occ_r && !(v < val_r);
      ge_r <= occ_r && !(val_r < v);
    end else if (cmd.ins) begin
      // cells above the insert point move up by one
      if (!le_r) begin
        if (left_le) begin
          val_r <= v;
          occ_r <= 1'b1;
        end else begin
          val_r <= $signed(left_val);
          occ_r <= left_occ;
        end
      end
    end else if (cmd.rem) begin
      // from the first copy upward everything moves down by one
      if (ge_r) begin
        val_r <= $signed(right_val);
        occ_r <= right_occ;
      end
    end
  end

  assign val    = val_r;
  assign occ    = occ_r;
  assign le     = le_r;
  assign ge     = ge_r;
  assign lo_val = (idx == lo_idx) ? val_r : '0;
  assign hi_val = (idx == hi_idx) ? val_r : '0;

endmodule

FILE: rtl/core/rmm_chain.sv
// ----------------------------------------------------------------------------
// rmm_chain
// row of sorted cells with neighbor links, match flag and middle readout
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmm_chain
  import rmm_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  rmm_cmd_t                     cmd,
  input  logic signed [VALUE_BITS-1:0] v,
  input  logic [IDX_W-1:0]             lo_idx,
  input  logic [IDX_W-1:0]             hi_idx,
  output logic                         found,
  output logic [VALUE_BITS-1:0]        lo_val,
  output logic [VALUE_BITS-1:0]        hi_val
);

  logic [VALUE_BITS-1:0] val_w [CAPACITY];
  logic [VALUE_BITS-1:0] lo_w  [CAPACITY];
  logic [VALUE_BITS-1:0] hi_w  [CAPACITY];
  logic [CAPACITY-1:0]   occ_w;
  logic [CAPACITY-1:0]   le_w;
  logic [CAPACITY-1:0]   ge_w;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] lv;
    logic                  lo_occ;
    logic                  lle;
    logic [VALUE_BITS-1:0] rv;
    logic                  ro;

    if (i == 0) begin : g_first
      assign lv     = '0;
      assign lo_occ = 1'b0;
      assign lle    = 1'b1;
    end else begin : g_mid
      assign lv     = val_w[i-1];
      assign lo_occ = occ_w[i-1];
      assign lle    = le_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rv = '0;
      assign ro = 1'b0;
    end else begin : g_inner
      assign rv = val_w[i+1];
      assign ro = occ_w[i+1];
    end

    rmm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .v         (v),
      .idx       (IDX_W'(i)),
      .lo_idx    (lo_idx),
      .hi_idx    (hi_idx),
      .left_val  (lv),
      .left_occ  (lo_occ),
      .left_le   (lle),
      .right_val (rv),
      .right_occ (ro),
      .val       (val_w[i]),
      .occ       (occ_w[i]),
      .le        (le_w[i]),
      .ge        (ge_w[i]),
      .lo_val    (lo_w[i]),
      .hi_val    (hi_w[i])
    );
  end

  assign found = |(le_w & ge_w);

  // only the addressed cells drive nonzero, so a plain or collects them
  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      lo_val = lo_val | lo_w[k];
      hi_val = hi_val | hi_w[k];
    end
  end

endmodule

FILE: rtl/core/rmm_checker.sv
// ----------------------------------------------------------------------------
// rmm_checker
// port-level checks for the running median block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmm_checker
  import rmm_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]    out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // error and empty results carry a zero median
  a_zero_med: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_VALID |-> out_tdata == '0)
    else $error("nonzero median on non-valid status");

  // one item at a time: input closes after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // a new result only appears out of the busy phase
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result without an item in flight");

  // nothing is pending right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind running_median_multiset rmm_checker u_rmm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: tb/running_median_multiset_chk.sv
// ----------------------------------------------------------------------------
// running_median_multiset_chk
// watches both streams, keeps a shadow sorted multiset and checks each result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module running_median_multiset_chk
  import rmm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] value
  input  logic [0:0]             in_tuser,   // [0] action
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // [32:0] median_twice
  input  logic [STATUS_W-1:0]    out_tuser,  // [1:0] status
  output int                     fail_count,
  output int                     pending,
  output int                     checked_count,
  output logic [3:0][15:0]       status_hits
);

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic signed [MED_BITS-1:0] median_twice;
  } median_report_t;

  logic signed [VALUE_BITS-1:0] sorted_vals [CAPACITY];
  int                           n_held;
  median_report_t               median_due_q [$];

  // applies one item to the shadow multiset and returns the report it causes
  function automatic median_report_t apply_to_multiset(
    input logic                         act,
    input logic signed [VALUE_BITS-1:0] v
  );
    median_report_t             r;
    logic signed [MED_BITS-1:0] lo;
    logic signed [MED_BITS-1:0] hi;
    int                         pos;
    int                         k;
    int                         h;
    r.status       = ST_VALID;
    r.median_twice = '0;
    pos            = 0;
    if (act == ACT_INSERT) begin
      if (n_held >= CAPACITY) begin
        r.status = ST_FULL;
        return r;
      end
      // new value goes after every equal copy
      while (pos < n_held && !(v < sorted_vals[pos])) pos++;
      for (k = n_held; k > pos; k--) sorted_vals[k] = sorted_vals[k-1];
      sorted_vals[pos] = v;
      n_held++;
    end else begin
      while (pos < n_held && sorted_vals[pos] != v) pos++;
      if (pos >= n_held) begin
        r.status = ST_NOT_HELD;
        return r;
      end
      for (k = pos; k < n_held - 1; k++) sorted_vals[k] = sorted_vals[k+1];
      n_held--;
    end
    if (n_held == 0) begin
      r.status = ST_EMPTY;
      return r;
    end
    h  = n_held / 2;
    hi = {sorted_vals[h][VALUE_BITS-1], sorted_vals[h]};
    if (n_held % 2 == 1) lo = hi;
    else lo = {sorted_vals[h-1][VALUE_BITS-1], sorted_vals[h-1]};
    r.median_twice = lo + hi;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fail_count < 100)
      $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
    fail_count++;
  endtask

  // sampled at the falling edge: what is seen here is taken at the next rise
  always @(negedge clk) begin : watch
    median_report_t want;
    if (!rst_n) begin
      n_held        = 0;
      fail_count    = 0;
      checked_count = 0;
      status_hits   = '0;
      median_due_q.delete();
    end else begin
      if (in_tvalid && in_tready)
        median_due_q.push_back(apply_to_multiset(in_tuser[0], in_tdata[VALUE_BITS-1:0]));
      if (out_tvalid && out_tready) begin
        if (median_due_q.size() == 0) begin
          report_mismatch("unexpected result", 64'({out_tuser, out_tdata}), '0);
        end else begin
          want = median_due_q.pop_front();
          checked_count++;
          status_hits[want.status] = status_hits[want.status] + 16'd1;
          if (out_tuser !== want.status)
            report_mismatch("status", 64'(out_tuser), 64'(want.status));
          if (out_tdata[MED_BITS-1:0] !== want.median_twice)
            report_mismatch("median_twice", 64'(out_tdata[MED_BITS-1:0]),
                            64'(want.median_twice));
        end
      end
    end
    pending = median_due_q.size();
  end

endmodule

FILE: tb/running_median_multiset_tb.sv
// ----------------------------------------------------------------------------
// running_median_multiset_tb
// drives insert and remove items into the running median block under several
// idle and stall mixes, with a checker alongside that predicts every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module running_median_multiset_tb;
  import rmm_pkg::*;

  localparam int TIMEOUT_NS = 5_000_000;
  localparam int MIX_ITEMS  = 410;
  localparam int HOLD_ITEMS = 60;

  // largest and smallest value of the signed field
  localparam logic [VALUE_BITS-1:0] MAX_V = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] MIN_V = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // [31:0] value
  logic [0:0]             in_tuser;    // [0] action
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // [32:0] median_twice
  logic [STATUS_W-1:0]    out_tuser;   // [1:0] status

  int                     fail_count;
  int                     pending;
  int                     checked_count;
  logic [3:0][15:0]       status_hits;

  // knobs for the sender and the receiver process
  int tx_gap_pct     = 0;
  int rx_stall_pct   = 0;
  int rx_hold_cycles = 0;
  int items_sent     = 0;

  // values the block should be holding, used only to aim removals
  logic [VALUE_BITS-1:0] held_pool [$];

  running_median_multiset dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  running_median_multiset_chk chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .status_hits   (status_hits)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stalls, plus one long counted hold when it is asked for
  initial begin : sink
    bit hold_done;
    hold_done  = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0 && !hold_done) begin
        out_tready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        hold_done = 1'b1;
      end
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // offers one item, waits for it to be taken, then tracks the held values;
  // in_tready is looked at on the falling edge so the sample is settled
  task automatic offer_item(input logic act, input logic [VALUE_BITS-1:0] val);
    bit took;
    int k;
    while ($urandom_range(99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= val;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end
    items_sent++;
    if (act == ACT_INSERT) begin
      if (held_pool.size() < CAPACITY) held_pool.push_back(val);
    end else begin
      for (k = 0; k < held_pool.size(); k++) begin
        if (held_pool[k] == val) begin
          held_pool.delete(k);
          break;
        end
      end
    end
  endtask

  // narrow band for duplicates, the field extremes, or anything at all
  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] v;
    int                    roll;
    roll = $urandom_range(99);
    if (roll < 30) begin
      v = VALUE_BITS'($urandom_range(16)) - VALUE_BITS'(8);
    end else if (roll < 42) begin
      case ($urandom_range(5))
        0: v = MAX_V;
        1: v = MIN_V;
        2: v = MAX_V - 1'b1;
        3: v = MIN_V + 1'b1;
        4: v = '1;
        default: v = '0;
      endcase
    end else begin
      v = $urandom();
    end
    return v;
  endfunction

  // mostly a value that is held, sometimes a stray one that likely is not
  function automatic logic [VALUE_BITS-1:0] pick_removal();
    if (held_pool.size() != 0 && $urandom_range(99) < 80)
      return held_pool[$urandom_range(held_pool.size() - 1)];
    return pick_value();
  endfunction

  // stretches that lean toward filling, churning or draining the store,
  // so full and empty are both reached many times
  task automatic run_mix(input int n_items);
    int done;
    int span;
    int ins_pct;
    done = 0;
    while (done < n_items) begin
      span = $urandom_range(150, 40);
      case ($urandom_range(3))
        0: ins_pct = 92;
        1: ins_pct = 60;
        2: ins_pct = 50;
        default: ins_pct = 15;
      endcase
      repeat (span) begin
        if ($urandom_range(99) < ins_pct) offer_item(ACT_INSERT, pick_value());
        else offer_item(ACT_REMOVE, pick_removal());
      end
      done += span;
    end
  endtask

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: removal from an empty set, doubled extremes, mixed signs,
    // duplicates, a stray removal from a non-empty set, draining to empty
    offer_item(ACT_REMOVE, VALUE_BITS'(5));
    offer_item(ACT_INSERT, MAX_V);
    offer_item(ACT_INSERT, MAX_V);
    offer_item(ACT_REMOVE, MAX_V);
    offer_item(ACT_REMOVE, MAX_V);
    offer_item(ACT_INSERT, MIN_V);
    offer_item(ACT_INSERT, MIN_V);
    offer_item(ACT_INSERT, MAX_V);
    offer_item(ACT_REMOVE, MIN_V);
    offer_item(ACT_REMOVE, '0);
    offer_item(ACT_INSERT, '1);
    offer_item(ACT_INSERT, VALUE_BITS'(1));
    offer_item(ACT_INSERT, '0);
    offer_item(ACT_REMOVE, VALUE_BITS'(7));
    offer_item(ACT_INSERT, '0);
    offer_item(ACT_REMOVE, '0);
    offer_item(ACT_REMOVE, MIN_V);
    offer_item(ACT_REMOVE, MAX_V);
    offer_item(ACT_REMOVE, '1);
    offer_item(ACT_REMOVE, VALUE_BITS'(1));
    offer_item(ACT_REMOVE, '0);

    // random mixes: free flow, sender gaps, receiver stalls, then both
    tx_gap_pct = 0;  rx_stall_pct = 0;  run_mix(MIX_ITEMS);
    tx_gap_pct = 46; rx_stall_pct = 0;  run_mix(MIX_ITEMS);
    tx_gap_pct = 0;  rx_stall_pct = 46; run_mix(MIX_ITEMS);
    tx_gap_pct = 33; rx_stall_pct = 33; run_mix(MIX_ITEMS);

    // long output hold while items keep coming, so the input side backs up
    tx_gap_pct     = 0;
    rx_stall_pct   = 0;
    rx_hold_cycles = 300;
    repeat (HOLD_ITEMS) begin
      if ($urandom_range(99) < 70) offer_item(ACT_INSERT, pick_value());
      else offer_item(ACT_REMOVE, pick_removal());
    end
    in_tvalid <= 1'b0;

    // drain, then a short quiet window to catch any stray result
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("run covered %0d items, %0d results checked over four idle mixes and a long hold",
             items_sent, checked_count);
    $display("statuses seen: median %0d, not held %0d, empty %0d, full %0d",
             status_hits[ST_VALID], status_hits[ST_NOT_HELD],
             status_hits[ST_EMPTY], status_hits[ST_FULL]);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
